>>> rtl/core/cbt_pkg.sv
// cbt_pkg: shared types and constants of the constant fraction timing unit
// used by cbt_seq, cfd_bisection_timing_unit and cbt_checker; no dependencies
package cbt_pkg;

  // command codes carried in tuser
  localparam logic [0:0] CMD_STORE = 1'b0;
  localparam logic [0:0] CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_FRACTION = 2'd0;
  localparam logic [1:0] REG_COUNT    = 2'd1;

  // fixed point: positions in sample periods with 14 fraction bits
  localparam int FRAC_BITS   = 14;
  localparam int FRAC_ONE    = 16384;
  localparam int HALF_SAMPLE = 8192;
  localparam int WINDOW_LEAD = 5;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 24;

  // query handed from the port side to the sequencer
  typedef struct packed {
    logic [15:0] fraction;
    logic [8:0]  count;
    logic [15:0] peak;
    logic [7:0]  low_bin;
  } query_t;

  // sequencer status back to the port side
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TIME_W-1:0] pulse_time;
  } seq_status_t;

endpackage

>>> rtl/core/cbt_ram.sv
// cbt_ram: generic single write port, single read port ram, registered read
// no dependencies
module cbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/cbt_seq.sv
// cbt_seq: peak scan and bisection sequencer reading the trace ram
// depends on cbt_pkg; drives the read port of a cbt_ram
module cbt_seq import cbt_pkg::*; #(
  parameter int TRACE_DEPTH = 256
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               start,
  input  query_t                                             query,
  input  logic                                               res_take,
  output seq_status_t                                        status,
  output logic                                               rd_en,
  output logic [(TRACE_DEPTH > 1 ? $clog2(TRACE_DEPTH) : 1)-1:0] rd_addr,
  input  logic [SAMPLE_W-1:0]                                rd_data
);

  localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int PW = ((AW > 8) ? AW : 8) + 16;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_INIT = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_MID  = 4'd4;
  localparam logic [3:0] ST_RDA  = 4'd5;
  localparam logic [3:0] ST_RDB  = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  query_t qr;
  logic [AW-1:0] nlast;
  logic [AW-1:0] scan_addr;
  logic          issued_all;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic signed [SAMPLE_W-1:0] best;
  logic [AW-1:0] peak_idx;

  logic signed [PW-1:0] lo;
  logic signed [PW-1:0] hi;
  logic signed [PW-1:0] mid;
  logic [31:0]          thr;
  logic [AW-1:0]        idx_b;
  logic [FRAC_BITS-1:0] frac;
  logic signed [32:0]   prod_a;
  logic signed [32:0]   prod_b;

  // count handling at start
  logic [12:0]   cnt_ext;
  logic [AW-1:0] nlast_in;

  // bisection datapath
  logic signed [PW:0]   diff;
  logic                 step_go;
  logic signed [PW-1:0] mid_in;
  logic signed [PW-1:0] u;
  logic signed [PW-1:0] u_lim;
  logic                 u_low;
  logic                 u_high;
  logic [AW-1:0]        idx_a;
  logic [FRAC_BITS-1:0] frac_in;

  logic signed [16:0]   mul_x;
  logic [14:0]          mul_w;
  logic signed [32:0]   mul_p;
  logic signed [33:0]   sum;
  logic signed [35:0]   sum4;
  logic signed [35:0]   thr_s;
  logic                 above;

  assign cnt_ext = 13'(query.count);

  always_comb begin
    if (query.count == 9'd0) begin
      nlast_in = '0;
    end else if (cnt_ext > 13'(TRACE_DEPTH)) begin
      nlast_in = AW'(TRACE_DEPTH - 1);
    end else begin
      nlast_in = AW'(cnt_ext - 13'd1);
    end
  end

  // loop test and midpoint
  assign diff    = (PW+1)'(hi) - (PW+1)'(lo);
  assign step_go = diff >= 2;
  assign mid_in  = lo + PW'(diff >>> 1);

  // sample index and weight of the midpoint, clamped to the end samples
  assign u       = mid - PW'(HALF_SAMPLE);
  assign u_lim   = $signed(PW'({nlast, {FRAC_BITS{1'b0}}}));
  assign u_low   = u <= 0;
  assign u_high  = u >= u_lim;
  assign frac_in = u[FRAC_BITS-1:0];

  always_comb begin
    if (u_low) begin
      idx_a = '0;
    end else if (u_high) begin
      idx_a = nlast;
    end else begin
      idx_a = u[AW+FRAC_BITS-1:FRAC_BITS];
    end
  end

  // one shared multiplier: negated sample times interpolation weight
  assign mul_x = -$signed({rd_data[SAMPLE_W-1], rd_data});
  assign mul_w = (state == ST_RDA) ? 15'(FRAC_ONE) - {1'b0, frac} : {1'b0, frac};
  assign mul_p = 33'(mul_x) * $signed({18'd0, mul_w});

  assign sum   = 34'(prod_a) + 34'(prod_b);
  assign sum4  = {sum, 2'b00};
  assign thr_s = $signed({4'd0, thr});
  assign above = sum4 > thr_s;

  // read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    unique case (state)
      ST_SCAN: begin
        rd_en   = !issued_all;
        rd_addr = scan_addr;
      end
      ST_MID: begin
        rd_en   = 1'b1;
        rd_addr = idx_a;
      end
      ST_RDA: begin
        rd_en   = frac != '0;
        rd_addr = idx_b;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (pend && pend_idx == nlast) state_next = ST_INIT;
      ST_INIT: state_next = ST_CHK;
      ST_CHK:  state_next = step_go ? ST_MID : ST_DONE;
      ST_MID:  state_next = ST_RDA;
      ST_RDA:  state_next = ST_RDB;
      ST_RDB:  state_next = ST_CMP;
      ST_CMP:  state_next = ST_CHK;
      ST_DONE: if (res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      issued_all <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            qr         <= query;
            nlast      <= nlast_in;
            scan_addr  <= '0;
            issued_all <= 1'b0;
            pend       <= 1'b0;
            lo         <= (PW'($signed({1'b0, query.low_bin})) - PW'(WINDOW_LEAD))
                          <<< FRAC_BITS;
          end
        end
        ST_SCAN: begin
          // one read issued and one sample compared per cycle
          pend     <= !issued_all;
          pend_idx <= scan_addr;
          if (!issued_all) begin
            scan_addr <= scan_addr + AW'(1);
            if (scan_addr == nlast) begin
              issued_all <= 1'b1;
            end
          end
          if (pend && (pend_idx == '0 || $signed(rd_data) < best)) begin
            best     <= $signed(rd_data);
            peak_idx <= pend_idx;
          end
        end
        ST_INIT: begin
          hi  <= $signed(PW'({peak_idx, {FRAC_BITS{1'b0}}})) + PW'(HALF_SAMPLE);
          thr <= 32'(qr.fraction) * 32'(qr.peak);
        end
        ST_CHK: begin
          mid <= mid_in;
        end
        ST_MID: begin
          frac  <= (u_low || u_high) ? '0 : frac_in;
          idx_b <= idx_a + AW'(1);
        end
        ST_RDA: begin
          prod_a <= mul_p;
        end
        ST_RDB: begin
          prod_b <= (frac == '0) ? '0 : mul_p;
        end
        ST_CMP: begin
          if (above) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.busy       = state != ST_IDLE;
  assign status.done       = state == ST_DONE;
  assign status.pulse_time = TIME_W'(lo);

endmodule

>>> rtl/core/cfd_bisection_timing_unit.sv
// cfd_bisection_timing_unit: constant fraction pulse timing by bisection, top level
// depends on cbt_pkg, cbt_ram and cbt_seq
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: index, sample, peak, low bin; s_tuser: command
//  m_       out  m_tvalid/m_tready  m_tdata: pulse_time
//  cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a store word writes the trace ram on acceptance
// a query runs a peak scan of n ram reads (n = samples in use), then bisection steps
// of up to two reads each on the single ram read port through one shared multiplier;
// up to about 22 steps when the window spans the trace
// rst is synchronous; trace contents stay undefined until written, no clearing pass
// s_tready is low while a query is worked on; a finished time waits in the output
// register, so a stalled m_tready only holds the unit once the next query is done
module cfd_bisection_timing_unit import cbt_pkg::*; #(
  parameter int TRACE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,    // sample_index[7:0], sample_value[23:8],
                                  // peak_amplitude[39:24], low_range_bin[47:40]
  input  logic [0:0]  s_tuser,    // command[0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // pulse_time[23:0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;

  logic [15:0] cfd_fraction;
  logic [8:0]  sample_count;

  logic          s_acc;
  logic          store_we;
  logic [AW-1:0] store_addr;
  logic          start;
  query_t        query;
  seq_status_t   status;
  logic          res_take;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfd_fraction <= 16'd32768;
      sample_count <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRACTION: cfd_fraction <= cfg_data;
        REG_COUNT:    sample_count <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // input side: one word in while the sequencer is idle
  assign s_tready = !status.busy;
  assign s_acc    = s_tvalid && s_tready;

  // stores beyond the trace depth are dropped
  assign store_we   = s_acc && s_tuser == CMD_STORE && 13'(s_tdata[7:0]) < 13'(TRACE_DEPTH);
  assign store_addr = AW'(s_tdata[7:0]);

  assign start          = s_acc && s_tuser == CMD_QUERY;
  assign query.fraction = cfd_fraction;
  assign query.count    = sample_count;
  assign query.peak     = s_tdata[39:24];
  assign query.low_bin  = s_tdata[47:40];

  cbt_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TRACE_DEPTH)
  ) u_trace (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (s_tdata[23:8]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cbt_seq #(
    .TRACE_DEPTH (TRACE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .query    (query),
    .res_take (res_take),
    .status   (status),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // output register: result moves in when empty or being drained
  assign res_take = status.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
      m_tdata  <= status.pulse_time;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/cbt_checker.sv
// cbt_checker: port level assertions for the timing unit, bound to the top level
// depends on cbt_pkg and cfd_bisection_timing_unit
module cbt_checker import cbt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a query occupies the unit
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_QUERY |=> !s_tready)
    else $error("input ready right after a query");

  // a store never occupies the unit
  a_store_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_STORE |=> s_tready)
    else $error("input stalled after a store");

  // a result only appears at the end of a query
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result word without a query in progress");

endmodule

bind cfd_bisection_timing_unit cbt_checker u_cbt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
